>>> rtl/hkft_pkg.sv
`default_nettype none
package hkft_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int TABLE_SLOTS = 2048;
  localparam int ENTRY_AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W       = ENTRY_AW + 1;
  localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
  localparam int SLOT_W      = ENTRY_AW + 1;
  localparam int HB_W        = 4;
  localparam int MIN_BITS    = 8;
  localparam logic [31:0] HASH_MULT = 32'd3141592653;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_OK       = 3'd2;
  localparam logic [2:0] ST_RANK     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [31:0]  key;
    logic [ENTRY_AW-1:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [CNT_W-1:0]   occurrences;
    logic signed [31:0] entry_key;
    logic [CNT_W-1:0]   distinct_total;
  } out_item_t;

  typedef struct packed {
    in_item_t    item;
    logic [31:0] prod;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

>>> rtl/hkft_ram.sv
`default_nettype none
module hkft_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/hkft_cmdq.sv
`default_nettype none
module hkft_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hkft_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output hkft_pkg::job_t     head
);
  import hkft_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

>>> rtl/hkft_front.sv
`default_nettype none
module hkft_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire hkft_pkg::in_item_t in_data,
  output logic                    in_full,
  input  wire hkft_pkg::back_stat_t bstat,
  input  wire logic               q_full,
  output logic                    q_push,
  output hkft_pkg::job_t          q_data
);
  import hkft_pkg::*;

  logic     st_v_r, st_v_nxt;
  job_t     st_r;
  logic     accept;

  assign in_full = bstat.clearing || (st_v_r && q_full);
  assign accept  = in_push && !in_full;
  assign q_push  = st_v_r;
  assign q_data  = st_r;

  always_comb begin
    st_v_nxt = st_v_r && q_full;
    if (accept && in_data.command != CMD_UNUSED) begin
      st_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= st_v_nxt;
    end
    if (accept) begin
      st_r.item <= in_data;
      st_r.prod <= 32'(in_data.key * HASH_MULT);
    end
  end
endmodule
`default_nettype wire

>>> rtl/hkft_back.sv
`default_nettype none
module hkft_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [hkft_pkg::HB_W-1:0] bits,
  input  wire logic                      q_valid,
  input  wire hkft_pkg::job_t            q_head,
  output logic                           q_pop,
  output hkft_pkg::back_stat_t           bstat,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output hkft_pkg::out_item_t            out_data
);
  import hkft_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_SLOT, S_KEY, S_READ, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_AW-1:0]  clr_idx_r, clr_idx_nxt;
  logic                clr_res_r, clr_res_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic [SLOT_AW-1:0]  id_r, id_nxt;
  logic [SLOT_AW:0]    probes_r, probes_nxt;
  logic [ENTRY_AW-1:0] ent_r, ent_nxt;
  logic [CNT_W-1:0]    dcount_r, dcount_nxt, seen_r, seen_nxt;
  out_item_t           res_r, res_nxt, out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  logic                slot_we;
  logic [SLOT_AW-1:0]  slot_waddr;
  logic [SLOT_W-1:0]   slot_wdata, slot_rdata;
  logic                key_we, cnt_we;
  logic [ENTRY_AW-1:0] ent_waddr, ent_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic [31:0]         key_rdata;

  logic [SLOT_AW:0]    nslots;
  logic [SLOT_AW-1:0]  mask, home;
  logic [SLOT_W-1:0]   s_m1;

  hkft_ram #(.W(SLOT_W), .D(TABLE_SLOTS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(id_r), .rdata(slot_rdata)
  );
  hkft_ram #(.W(32), .D(MAX_ITEMS)) u_keys (
    .clk(clk), .we(key_we), .waddr(ent_waddr), .wdata(key_r),
    .raddr(ent_raddr), .rdata(key_rdata)
  );
  hkft_ram #(.W(CNT_W), .D(MAX_ITEMS)) u_cnts (
    .clk(clk), .we(cnt_we), .waddr(ent_waddr), .wdata(cnt_wdata),
    .raddr(ent_raddr), .rdata(cnt_rdata)
  );

  assign nslots         = (SLOT_AW + 1)'(1) << bits;
  assign mask           = SLOT_AW'(nslots - 1'b1);
  assign home           = q_head.prod[31 -: SLOT_AW] >> (HB_W'(SLOT_AW) - bits);
  assign s_m1           = slot_rdata - 1'b1;
  assign bstat.clearing = (state_r == S_CLEAR);
  assign out_empty      = !out_v_r;
  assign out_data       = out_r;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    clr_res_nxt = clr_res_r;
    key_nxt     = key_r;
    id_nxt      = id_r;
    probes_nxt  = probes_r;
    ent_nxt     = ent_r;
    dcount_nxt  = dcount_r;
    seen_nxt    = seen_r;
    res_nxt     = res_r;
    out_v_nxt   = out_v_r && !out_pop;
    out_nxt     = out_r;
    q_pop       = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = id_r;
    slot_wdata  = '0;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    ent_waddr   = ent_r;
    ent_raddr   = ent_r;
    cnt_wdata   = '0;
    unique case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          dcount_nxt = '0;
          seen_nxt   = '0;
          if (clr_res_r) begin
            res_nxt   = '{ST_OK, '0, '0, '0};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          key_nxt = q_head.item.key;
          unique case (q_head.item.command)
            CMD_INSERT: begin
              if (seen_r >= CNT_W'(MAX_ITEMS)) begin
                res_nxt   = '{ST_FULL, '0, q_head.item.key, dcount_r};
                state_nxt = S_OUT;
              end else begin
                id_nxt     = home;
                probes_nxt = '0;
                state_nxt  = S_ISSUE;
              end
            end
            CMD_READ: begin
              if (CNT_W'(q_head.item.rank) < dcount_r) begin
                ent_raddr = q_head.item.rank;
                state_nxt = S_READ;
              end else begin
                res_nxt   = '{ST_RANK, '0, '0, dcount_r};
                state_nxt = S_OUT;
              end
            end
            CMD_CLEAR: begin
              clr_idx_nxt = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_ISSUE: begin
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        if (slot_rdata == '0) begin
          if (dcount_r >= CNT_W'(MAX_ITEMS)) begin
            res_nxt   = '{ST_FULL, '0, key_r, dcount_r};
            state_nxt = S_OUT;
          end else begin
            slot_we    = 1'b1;
            slot_wdata = SLOT_W'(dcount_r + 1'b1);
            key_we     = 1'b1;
            cnt_we     = 1'b1;
            ent_waddr  = ENTRY_AW'(dcount_r);
            cnt_wdata  = CNT_W'(1);
            dcount_nxt = dcount_r + 1'b1;
            seen_nxt   = seen_r + 1'b1;
            res_nxt    = '{ST_NEW, CNT_W'(1), key_r, dcount_r + 1'b1};
            state_nxt  = S_OUT;
          end
        end else if (CNT_W'(s_m1) < dcount_r) begin
          ent_nxt   = ENTRY_AW'(s_m1);
          ent_raddr = ENTRY_AW'(s_m1);
          state_nxt = S_KEY;
        end else if (probes_r + 1'b1 == nslots) begin
          res_nxt   = '{ST_FULL, '0, key_r, dcount_r};
          state_nxt = S_OUT;
        end else begin
          id_nxt     = (id_r + 1'b1) & mask;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_ISSUE;
        end
      end
      S_KEY: begin
        if (key_rdata == key_r) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + 1'b1;
          seen_nxt  = seen_r + 1'b1;
          res_nxt   = '{ST_EXISTING, cnt_rdata + 1'b1, key_r, dcount_r};
          state_nxt = S_OUT;
        end else if (probes_r + 1'b1 == nslots) begin
          res_nxt   = '{ST_FULL, '0, key_r, dcount_r};
          state_nxt = S_OUT;
        end else begin
          id_nxt     = (id_r + 1'b1) & mask;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_ISSUE;
        end
      end
      S_READ: begin
        res_nxt   = '{ST_OK, cnt_rdata, key_rdata, dcount_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_v_r || out_pop) begin
          out_v_nxt = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      clr_res_r <= 1'b0;
      dcount_r  <= '0;
      seen_r    <= '0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_res_r <= clr_res_nxt;
      dcount_r  <= dcount_nxt;
      seen_r    <= seen_nxt;
      out_v_r   <= out_v_nxt;
    end
    key_r    <= key_nxt;
    id_r     <= id_nxt;
    probes_r <= probes_nxt;
    ent_r    <= ent_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/hashed_key_frequency_table_unit.sv
`default_nettype none
// Counts occurrences of 32-bit keys in an open-addressed hash table with linear
// probing. Insert steps the back end through a slot issue, a slot read and, on an
// occupied slot, a key compare per probe, set by the registered read of the slot
// memory and the entry memories; read waits on the registered entry read. Clear,
// and reset, sweep all slots, while in_full is high. Write cfg_wdata (hash_bits,
// saturated to 8..11) only while idle, then clear the table before inserting.
module hashed_key_frequency_table_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire hkft_pkg::in_item_t          in_data,
  output logic                             in_full,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output hkft_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [hkft_pkg::HB_W-1:0]   cfg_wdata
);
  import hkft_pkg::*;

  logic [HB_W-1:0] hash_bits_r, bits;
  back_stat_t      bstat;
  logic            q_push, q_full, q_valid, q_pop;
  job_t            q_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_bits_r <= HB_W'(SLOT_AW);
    end else if (cfg_we) begin
      hash_bits_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (hash_bits_r < HB_W'(MIN_BITS)) begin
      bits = HB_W'(MIN_BITS);
    end else if (hash_bits_r > HB_W'(SLOT_AW)) begin
      bits = HB_W'(SLOT_AW);
    end else begin
      bits = hash_bits_r;
    end
  end

  hkft_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .bstat(bstat), .q_full(q_full), .q_push(q_push),
    .q_data(q_data)
  );

  hkft_cmdq u_q (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  hkft_back u_back (
    .clk(clk), .rst_n(rst_n), .bits(bits), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .bstat(bstat), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

>>> bench/tb_hashed_key_frequency_table_unit.sv
`timescale 1ns / 1ps
module tb_hashed_key_frequency_table_unit;
  import hkft_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 2200;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  typedef struct {
    bit        typed;
    out_item_t want;
  } override_t;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  in_item_t            in_data;
  logic                in_full;
  logic                out_empty;
  logic                out_pop;
  out_item_t           out_data;
  logic                cfg_we;
  logic [HB_W-1:0]     cfg_wdata;

  hashed_key_frequency_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [SLOT_W-1:0] slot_tab [TABLE_SLOTS];
  logic [31:0]       stored_keys [MAX_ITEMS];
  int unsigned       stored_counts [MAX_ITEMS];
  int unsigned       distinct_seen;
  int unsigned       inserts_seen;
  logic [HB_W-1:0]   hash_bits_q;

  out_item_t  pending_results [$];
  override_t  typed_q [$];
  dir_row_t   dir_tab [$];
  logic [31:0] key_pool [64];

  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  full_seen;
  int  rank_miss_seen;
  int  quiet_cycles;
  bit  no_idle;
  bit  hold_req;
  int  stall_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void wipe_slots();
    foreach (slot_tab[i]) slot_tab[i] = '0;
    distinct_seen = 0;
    inserts_seen = 0;
  endfunction

  function automatic bit predict_command(input in_item_t it, output out_item_t r);
    int unsigned b, nslots, id, s, occ;
    logic [31:0] k, prod;
    logic [2:0] st;
    bit done;
    k = it.key;
    occ = 0;
    done = 0;
    case (it.command)
      CMD_INSERT: begin
        b = hash_bits_q < MIN_BITS ? MIN_BITS :
            (hash_bits_q > SLOT_AW ? SLOT_AW : hash_bits_q);
        nslots = 1 << b;
        prod = HASH_MULT * k;
        id = prod >> (32 - b);
        st = ST_FULL;
        if (inserts_seen < MAX_ITEMS) begin
          for (int p = 0; p < nslots && !done; p++) begin
            s = slot_tab[id];
            if (s == 0) begin
              if (distinct_seen >= MAX_ITEMS) break;
              slot_tab[id] = SLOT_W'(distinct_seen + 1);
              stored_keys[distinct_seen] = k;
              stored_counts[distinct_seen] = 1;
              distinct_seen++;
              inserts_seen++;
              st = ST_NEW;
              occ = 1;
              done = 1;
            end else if (s - 1 < distinct_seen && stored_keys[s-1] == k) begin
              stored_counts[s-1]++;
              inserts_seen++;
              st = ST_EXISTING;
              occ = stored_counts[s-1];
              done = 1;
            end else begin
              id = (id + 1) & (nslots - 1);
            end
          end
        end
      end
      CMD_READ: begin
        if (it.rank < distinct_seen) begin
          st = ST_OK;
          occ = stored_counts[it.rank];
          k = stored_keys[it.rank];
        end else begin
          st = ST_RANK;
          k = '0;
        end
      end
      CMD_CLEAR: begin
        wipe_slots();
        st = ST_OK;
        k = '0;
      end
      default: return 0;
    endcase
    r.status = st;
    r.occurrences = CNT_W'(occ);
    r.entry_key = k;
    r.distinct_total = CNT_W'(distinct_seen);
    return 1;
  endfunction

  // input and config monitor, predictor update, watchdog
  always @(posedge clk) begin
    out_item_t r;
    override_t ov;
    bit busy;
    busy = 0;
    if (rst_n && cfg_we) hash_bits_q = cfg_wdata;
    if (rst_n && in_push && !in_full) begin
      busy = 1;
      ov = typed_q.pop_front();
      if (predict_command(in_data, r)) begin
        if (ov.typed) r = ov.want;
        if (r.status == ST_FULL) full_seen++;
        if (r.status == ST_RANK) rank_miss_seen++;
        pending_results.push_back(r);
      end
    end
    if (rst_n && out_pop && !out_empty) begin
      busy = 1;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        r = pending_results.pop_front();
        if (out_data.status !== r.status || out_data.occurrences !== r.occurrences ||
            out_data.entry_key !== r.entry_key ||
            out_data.distinct_total !== r.distinct_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d occ=%0d key=%h dist=%0d, ",
                      "got st=%0d occ=%0d key=%h dist=%0d"},
                     r.status, r.occurrences, r.entry_key, r.distinct_total,
                     out_data.status, out_data.occurrences, out_data.entry_key,
                     out_data.distinct_total);
        end
      end
    end
    quiet_cycles = busy ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      stall_left <= 400;
      out_pop <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic send(input in_item_t it, input bit typed = 0, input out_item_t want = '0);
    override_t ov;
    ov.typed = typed;
    ov.want = want;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    typed_q.push_back(ov);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_hash_bits(input logic [HB_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mode 0: mixed with clears, 1: mostly fresh keys, 2: pool keys without clears
  function automatic in_item_t make_item(input int mode);
    in_item_t it;
    int sel;
    it.key = $urandom;
    it.rank = ENTRY_AW'($urandom_range(0, MAX_ITEMS - 1));
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      it.command = CMD_INSERT;
      if (mode == 2 || (mode == 0 && sel < 50)) it.key = key_pool[$urandom_range(0, 63)];
    end else if (sel < 94 || mode != 0) begin
      it.command = (sel >= 98 && mode != 2) ? CMD_UNUSED : CMD_READ;
      if (distinct_seen > 0 && sel[0])
        it.rank = ENTRY_AW'($urandom_range(0, distinct_seen - 1));
    end else if (sel < 97) begin
      it.command = CMD_CLEAR;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  function automatic void add_row(input logic [1:0] c, input logic [31:0] k,
                                  input int r, input bit typed,
                                  input logic [2:0] st = 0, input int occ = 0,
                                  input logic [31:0] ek = 0, input int dtot = 0);
    dir_row_t row;
    row.item.command = c;
    row.item.key = k;
    row.item.rank = ENTRY_AW'(r);
    row.typed = typed;
    row.want.status = st;
    row.want.occurrences = CNT_W'(occ);
    row.want.entry_key = ek;
    row.want.distinct_total = CNT_W'(dtot);
    dir_tab.push_back(row);
  endfunction

  task automatic run_random(input int mode, input int count, input int pause_at = -1);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send(make_item(mode));
    end
  endtask

  initial begin
    in_item_t clr;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    full_seen = 0;
    rank_miss_seen = 0;
    quiet_cycles = 0;
    no_idle = 0;
    hold_req = 0;
    stall_left = 0;
    hash_bits_q = 4'd11;
    wipe_slots();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hFFFF_FFFF;
    clr = '0;
    clr.command = CMD_CLEAR;

    add_row(CMD_READ,   32'h0,         0,    1, ST_RANK, 0, 32'h0, 0);
    add_row(CMD_INSERT, 32'h8000_0000, 0,    1, ST_NEW, 1, 32'h8000_0000, 1);
    add_row(CMD_INSERT, 32'h7FFF_FFFF, 1023, 1, ST_NEW, 1, 32'h7FFF_FFFF, 2);
    add_row(CMD_INSERT, 32'h0,         0,    1, ST_NEW, 1, 32'h0, 3);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 0,    1, ST_NEW, 1, 32'hFFFF_FFFF, 4);
    add_row(CMD_INSERT, 32'h0,         0,    1, ST_EXISTING, 2, 32'h0, 4);
    add_row(CMD_READ,   32'hFFFF_FFFF, 0,    1, ST_OK, 1, 32'h8000_0000, 4);
    add_row(CMD_READ,   32'h0,         2,    1, ST_OK, 2, 32'h0, 4);
    add_row(CMD_READ,   32'h0,         4,    1, ST_RANK, 0, 32'h0, 4);
    add_row(CMD_READ,   32'h0,         1023, 1, ST_RANK, 0, 32'h0, 4);
    add_row(CMD_UNUSED, 32'h1234_5678, 5,    0);
    add_row(CMD_INSERT, 32'h5555_5555, 1023, 0);
    add_row(CMD_INSERT, 32'hAAAA_AAAA, 682,  0);
    add_row(CMD_INSERT, 32'h8000_0000, 341,  0);
    add_row(CMD_READ,   32'h0,         5,    0);
    add_row(CMD_CLEAR,  32'hFFFF_FFFF, 1023, 1, ST_OK, 0, 32'h0, 0);
    add_row(CMD_READ,   32'h0,         0,    1, ST_RANK, 0, 32'h0, 0);
    add_row(CMD_INSERT, 32'hAAAA_AAAA, 0,    0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    // smallest table, filled past its slots
    write_hash_bits(4'd8);
    send(clr);
    run_random(1, 400);

    // grow the table without clearing
    write_hash_bits(4'd9);
    run_random(0, 40);

    // below the floor, mixed traffic with a long receiver hold-off
    write_hash_bits(4'd0);
    send(clr);
    hold_req = 1;
    run_random(0, 130, 70);

    // above the ceiling, repeated keys only
    write_hash_bits(4'd15);
    send(clr);
    run_random(2, 60);

    write_hash_bits(4'd11);
    send(clr);
    no_idle = 1;
    run_random(0, 100);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands sent, %0d results checked over hash widths 8 to 11", items_sent,
             results_checked);
    $display("%0d capacity overflows and %0d out-of-range reads predicted", full_seen,
             rank_miss_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
